@@ rtl/dcsq_pkg.sv @@
// Shared types and constants for the density column surface query block.
package dcsq_pkg;

   localparam int IDX_W   = 12;
   localparam int DENS_W  = 16;
   localparam int COORD_W = 24;
   localparam int CSZ_W   = 16;
   localparam int NCELL_W = 4;
   localparam int LVL_W   = 52;   // bilinear level density, scaled by d*d

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] STATUS_FOUND   = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_NONE    = 2'd2;

   localparam logic CSR_CELL_SIZE  = 1'b0;
   localparam logic CSR_CELLS_USED = 1'b1;

   localparam logic [CSZ_W-1:0]   CELL_SIZE_RESET  = 16'd256;
   localparam logic [NCELL_W-1:0] CELLS_USED_RESET = 4'd15;

   typedef struct packed {
      logic                      op;
      logic [IDX_W-1:0]          sample_index;
      logic signed [DENS_W-1:0]  density_value;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [COORD_W-1:0] height;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SETUP, S_MAP, S_DIVXY, S_WEIGHT,
      S_LEVEL, S_CHECK, S_DIVQ, S_HMUL, S_HSUM
   } ctrl_state_type;

   typedef struct packed {
      logic       clear_step;
      logic       write_item;
      logic       load_query;
      logic       setup;
      logic       map;
      logic       divxy_step;
      logic [1:0] divxy_bit;
      logic       weight;
      logic       acc_clear;
      logic       rd_issue;
      logic [1:0] rd_corner;
      logic       check;
      logic       divq_step;
      logic       divq_first;
      logic       hmul;
      logic       finish;
      logic [1:0] fin_status;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic outside;
      logic crossed;
      logic last_level;
   } sts_type;

endpackage

@@ rtl/density_column_surface_query.sv @@
// Top level of the density column surface query block: CSR port and wiring.
//
//  channel  | ports                        | beat taken when
//  ---------+------------------------------+----------------------------------
//  request  | start, busy, req_payload     | start & !busy
//  result   | rsp_strobe, rsp_payload      | rsp_strobe (one cycle, no stall)
//  config   | psel..pready (APB style)     | psel & penable & pwrite & pready
//
// A sample write is taken in idle and keeps busy low. A query off the grid
// answers once the setup and map states have run. A query scans levels one
// at a time (four reads from the single read port of the sample RAM plus
// multiply/accumulate); it answers after the divide and height steps if a
// crossing is found, else after all n+1 levels, n being the cells in use.
// After reset a clearing pass over SAMPLES_PER_AXIS^3 entries (4096 by
// default) zeroes the store; busy stays high meanwhile, CSR writes still go.
// Results cannot be stalled; busy drops in the cycle the result is shown.
module density_column_surface_query #(
   parameter int SAMPLES_PER_AXIS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dcsq_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output dcsq_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import dcsq_pkg::*;

   logic [CSZ_W-1:0]   cell_size_ff;
   logic [NCELL_W-1:0] cells_used_ff;
   logic               csr_wr;
   logic               csr_index;

   assign pready    = 1'b1;
   assign csr_wr    = psel & penable & pwrite & pready;
   assign csr_index = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff  <= CELL_SIZE_RESET;
         cells_used_ff <= CELLS_USED_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_CELL_SIZE:  cell_size_ff  <= pwdata[CSZ_W-1:0];
            default:        cells_used_ff <= pwdata[NCELL_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_CELL_SIZE: prdata = {16'd0, cell_size_ff};
         default:       prdata = {28'd0, cells_used_ff};
      endcase
   end

   cmd_type cmd;
   sts_type sts;

   dcsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_payload.op),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   dcsq_datapath #(.SAMPLES_PER_AXIS(SAMPLES_PER_AXIS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_payload),
      .cell_size  (cell_size_ff),
      .cells_used (cells_used_ff),
      .sts        (sts),
      .rsp        (rsp_payload)
   );
endmodule

@@ rtl/dcsq_ram.sv @@
// Generic simple dual-port RAM with registered read.
module dcsq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/dcsq_ctrl.sv @@
// Sequencer for the surface query: clear pass, sample writes, mapping, level scan, divide, height.
module dcsq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_op,
   input  dcsq_pkg::sts_type sts,
   output dcsq_pkg::cmd_type cmd,
   output logic              busy,
   output logic              rsp_strobe
);
   import dcsq_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic           rsp_strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_op == OP_QUERY) begin
                  cmd.load_query = 1'b1;
                  state_in       = S_SETUP;
               end else begin
                  cmd.write_item = 1'b1;
               end
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_MAP;
         end
         S_MAP: begin
            cmd.map = 1'b1;
            cnt_in  = '0;
            if (sts.outside) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = STATUS_OUTSIDE;
               state_in       = S_IDLE;
            end else begin
               state_in = S_DIVXY;
            end
         end
         S_DIVXY: begin
            cmd.divxy_step = 1'b1;
            cmd.divxy_bit  = ~cnt_ff[1:0];
            if (cnt_ff == 5'd3) begin
               cnt_in   = '0;
               state_in = S_WEIGHT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_WEIGHT: begin
            cmd.weight = 1'b1;
            cnt_in     = '0;
            state_in   = S_LEVEL;
         end
         S_LEVEL: begin
            cmd.acc_clear = (cnt_ff == 5'd0);
            cmd.rd_issue  = (cnt_ff < 5'd4);
            cmd.rd_corner = cnt_ff[1:0];
            if (cnt_ff == 5'd5) begin
               cnt_in   = '0;
               state_in = S_CHECK;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = '0;
            if (sts.crossed) begin
               state_in = S_DIVQ;
            end else if (sts.last_level) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = STATUS_NONE;
               state_in       = S_IDLE;
            end else begin
               state_in = S_LEVEL;
            end
         end
         S_DIVQ: begin
            cmd.divq_step  = 1'b1;
            cmd.divq_first = (cnt_ff == 5'd0);
            if (cnt_ff == 5'd16) begin
               cnt_in   = '0;
               state_in = S_HMUL;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_HMUL: begin
            cmd.hmul = 1'b1;
            state_in = S_HSUM;
         end
         S_HSUM: begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STATUS_FOUND;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

   // results never come back to back: a query runs through the setup and map states before it can answer
   a_no_double_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result beats back to back");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && req_op == OP_QUERY) |=> state_ff == S_SETUP)
      else $error("accepted query did not start");

   a_beat_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) != S_IDLE && $past(state_ff) != S_CLEAR))
      else $error("result beat without a query in flight");
endmodule

@@ rtl/dcsq_datapath.sv @@
// Datapath: sample store, grid mapping, bilinear accumulate, crossing divide, height.
module dcsq_datapath #(
   parameter int SAMPLES_PER_AXIS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dcsq_pkg::cmd_type             cmd,
   input  dcsq_pkg::req_type             req,
   input  logic [dcsq_pkg::CSZ_W-1:0]    cell_size,
   input  logic [dcsq_pkg::NCELL_W-1:0]  cells_used,
   output dcsq_pkg::sts_type             sts,
   output dcsq_pkg::rsp_type             rsp
);
   import dcsq_pkg::*;

   localparam int DEPTH = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;
   localparam int AW    = $clog2(DEPTH);
   localparam int NMAX  = SAMPLES_PER_AXIS - 1;

   // clear pass
   logic [AW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // store ports
   logic                  in_range;
   logic [AW+IDX_W-1:0]   widx_wide;
   logic [AW+IDX_W-1:0]   ridx_wide;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [AW-1:0]         ram_raddr;
   logic [DENS_W-1:0]     ram_wdata;
   logic [DENS_W-1:0]     ram_rdata;
   logic [IDX_W-1:0]      rd_addr;

   assign in_range  = int'({20'd0, req.sample_index}) < DEPTH;
   assign widx_wide = {{AW{1'b0}}, req.sample_index};
   assign ridx_wide = {{AW{1'b0}}, rd_addr};
   assign ram_we    = cmd.clear_step | (cmd.write_item & in_range);
   assign ram_waddr = cmd.clear_step ? clr_ff : widx_wide[AW-1:0];
   assign ram_wdata = cmd.clear_step ? '0 : req.density_value;
   assign ram_raddr = ridx_wide[AW-1:0];

   dcsq_ram #(.WIDTH(DENS_W), .DEPTH(DEPTH)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // effective configuration
   logic [NCELL_W-1:0] n_sel;
   logic [CSZ_W-1:0]   c_sel;
   always_comb begin
      if (cells_used == '0) begin
         n_sel = 4'd1;
      end else if (int'(cells_used) > NMAX) begin
         n_sel = NCELL_W'(NMAX);
      end else begin
         n_sel = cells_used;
      end
      c_sel = (cell_size < 16'd256) ? 16'd256 : cell_size;
   end

   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic [NCELL_W-1:0]        n_ff;
   logic [CSZ_W-1:0]          c_ff;
   logic [16:0]               d_ff;
   logic [19:0]               nc_ff;

   // grid mapping
   logic [25:0] nx, ny;
   logic [20:0] nd;
   logic        outside;
   assign nx      = {px_ff[23], px_ff, 1'b0} + {6'd0, nc_ff};
   assign ny      = {py_ff[23], py_ff, 1'b0} + {6'd0, nc_ff};
   assign nd      = {nc_ff, 1'b0};
   assign outside = nx[25] | ny[25] | (nx[24:0] > {4'd0, nd}) | (ny[24:0] > {4'd0, nd});

   // base cell division, one quotient bit per cycle
   logic [20:0] remx_ff, remy_ff;
   logic [3:0]  qx_ff, qy_ff;
   logic [20:0] dsh;
   assign dsh = 21'(d_ff) << cmd.divxy_bit;

   // clamp at the far edge and weights
   logic [3:0]  x0c, y0c;
   logic [16:0] rxc, ryc;
   logic [4:0]  s5;
   always_comb begin
      if (qx_ff == n_ff) begin
         x0c = n_ff - 4'd1;
         rxc = d_ff;
      end else begin
         x0c = qx_ff;
         rxc = remx_ff[16:0];
      end
      if (qy_ff == n_ff) begin
         y0c = n_ff - 4'd1;
         ryc = d_ff;
      end else begin
         y0c = qy_ff;
         ryc = remy_ff[16:0];
      end
      s5 = {1'b0, n_ff} + 5'd1;
   end

   logic [33:0]      w_ff [4];
   logic [IDX_W-1:0] base_ff, plane_ff;
   logic [4:0]       s_ff;
   logic [3:0]       z_ff, zx_ff;

   // corner reads: bit 0 steps x, bit 1 steps y
   always_comb begin
      unique case (cmd.rd_corner)
         2'd0:    rd_addr = base_ff;
         2'd1:    rd_addr = base_ff + IDX_W'(1);
         2'd2:    rd_addr = base_ff + IDX_W'(s_ff);
         default: rd_addr = base_ff + IDX_W'(s_ff) + IDX_W'(1);
      endcase
   end

   logic              rd_vld_ff, prod_vld_ff;
   logic [1:0]        rd_corner_ff;
   logic signed [50:0] prod, prod_ff;
   logic signed [LVL_W-1:0] acc_ff, below_ff;
   assign prod = $signed(ram_rdata) * $signed({1'b0, w_ff[rd_corner_ff]});

   logic below_pos, acc_nonpos;
   assign below_pos  = !below_ff[LVL_W-1] && (below_ff != '0);
   assign acc_nonpos = acc_ff[LVL_W-1] || (acc_ff == '0);

   // fraction divide
   logic [LVL_W-1:0] r_ff, den_ff, rt;
   logic [16:0]      q_ff;
   assign rt = cmd.divq_first ? r_ff : {r_ff[LVL_W-2:0], 1'b0};

   // height
   logic [32:0]        qc_ff;
   logic signed [22:0] zc_ff;
   logic signed [5:0]  zterm;
   logic [41:0]        hsum;
   assign zterm = $signed({1'b0, zx_ff, 1'b0} - {2'b00, n_ff});
   assign hsum  = {{3{zc_ff[22]}}, zc_ff, 16'd0} + {8'd0, qc_ff, 1'b0} + 42'd65536;

   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.rd_issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_corner_ff <= cmd.rd_corner;
      prod_ff      <= prod;
      if (cmd.load_query) begin
         px_ff <= req.point_x;
         py_ff <= req.point_y;
      end
      if (cmd.setup) begin
         n_ff  <= n_sel;
         c_ff  <= c_sel;
         d_ff  <= {c_sel, 1'b0};
         nc_ff <= 20'(n_sel) * 20'(c_sel);
      end
      if (cmd.map) begin
         remx_ff <= nx[20:0];
         remy_ff <= ny[20:0];
         qx_ff   <= '0;
         qy_ff   <= '0;
      end
      if (cmd.divxy_step) begin
         if (remx_ff >= dsh) begin
            remx_ff               <= remx_ff - dsh;
            qx_ff[cmd.divxy_bit]  <= 1'b1;
         end
         if (remy_ff >= dsh) begin
            remy_ff               <= remy_ff - dsh;
            qy_ff[cmd.divxy_bit]  <= 1'b1;
         end
      end
      if (cmd.weight) begin
         w_ff[0]  <= (d_ff - rxc) * (d_ff - ryc);
         w_ff[1]  <= rxc * (d_ff - ryc);
         w_ff[2]  <= (d_ff - rxc) * ryc;
         w_ff[3]  <= rxc * ryc;
         base_ff  <= IDX_W'(y0c) * IDX_W'(s5) + IDX_W'(x0c);
         plane_ff <= IDX_W'(s5) * IDX_W'(s5);
         s_ff     <= s5;
         z_ff     <= '0;
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + {{(LVL_W-51){prod_ff[50]}}, prod_ff};
      end
      if (cmd.check) begin
         if (sts.crossed) begin
            r_ff   <= below_ff;
            den_ff <= below_ff - acc_ff;
            q_ff   <= '0;
            zx_ff  <= z_ff - 4'd1;
         end else begin
            below_ff <= acc_ff;
            z_ff     <= z_ff + 4'd1;
            base_ff  <= base_ff + plane_ff;
         end
      end
      if (cmd.divq_step) begin
         if (rt >= den_ff) begin
            r_ff <= rt - den_ff;
            q_ff <= {q_ff[15:0], 1'b1};
         end else begin
            r_ff <= rt;
            q_ff <= {q_ff[15:0], 1'b0};
         end
      end
      if (cmd.hmul) begin
         qc_ff <= 33'(q_ff) * 33'(c_ff);
         zc_ff <= zterm * $signed({1'b0, c_ff});
      end
      if (cmd.finish) begin
         rsp_ff.status <= cmd.fin_status;
         rsp_ff.height <= (cmd.fin_status == STATUS_FOUND) ? hsum[40:17] : '0;
      end
   end

   assign sts.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign sts.outside    = outside;
   assign sts.crossed    = (z_ff != '0) && below_pos && acc_nonpos;
   assign sts.last_level = (z_ff == n_ff);
   assign rsp            = rsp_ff;
endmodule
